/* hw/rtl/dsg_pkg.sv */
// ----------------------------------------------------------------------------
// dsg_pkg
// shared types, register indexes and the quarter-wave sine table function
// ----------------------------------------------------------------------------
package dsg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [2:0] REG_DECAY_FACTOR = 3'd2;
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd3;

    localparam logic [31:0] ENV_ONE     = 32'h8000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // taylor term divisors (2n)(2n+1)
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // entries of the state memory
    typedef enum logic [1:0] {
        ENT_PHASE = 2'd0,
        ENT_ENV   = 2'd1,
        ENT_INDEX = 2'd2,
        ENT_PEAK  = 2'd3
    } t_entry;

    typedef struct packed {
        logic        we;
        t_entry      waddr;
        logic [31:0] wdata;
        t_entry      raddr;
    } t_mem_req;

    // one quarter-wave entry, evaluated at elaboration only
    function automatic logic [31:0] sine_entry(input int unsigned k,
                                               input int unsigned addr_bits,
                                               input int unsigned sample_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] full;
        logic [63:0] scaled;
        longint      acc;
        full = (64'd1 << (sample_bits - 1)) - 64'd1;
        x    = (64'(k) * HALF_PI_Q30 + ((64'd1 << addr_bits) >> 1)) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) != 0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30)) begin
            acc = longint'(ONE_Q30);
        end
        scaled = (64'(acc) * full + (ONE_Q30 >> 1)) >> 30;
        return scaled[31:0];
    endfunction

endpackage

/* hw/rtl/dsg_sine_rom.sv */
// ----------------------------------------------------------------------------
// dsg_sine_rom
// quarter-wave sine rom, 2^ADDR_BITS + 1 entries, registered read
// ----------------------------------------------------------------------------
module dsg_sine_rom
    import dsg_pkg::*;
#(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [ADDR_BITS:0]     i_addr,
    output logic [SAMPLE_BITS-2:0] o_data
);
    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    logic [SAMPLE_BITS-2:0] rom_tab [0:DEPTH-1];
    logic [SAMPLE_BITS-2:0] r_data;

    for (genvar k = 0; k < DEPTH; k++) begin : g_tab
        assign rom_tab[k] = (SAMPLE_BITS-1)'(sine_entry(k, ADDR_BITS, SAMPLE_BITS));
    end

    always_ff @(posedge i_clk) begin
        r_data <= rom_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/dsg_state_mem.sv */
// ----------------------------------------------------------------------------
// dsg_state_mem
// four-entry tone state memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dsg_state_mem
    import dsg_pkg::*;
(
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);
    logic [31:0] mem [0:3];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/decaying_sine_generator.sv */
// ----------------------------------------------------------------------------
// decaying_sine_generator
// damped sine tone generator, at most one sample per tick transfer
// ----------------------------------------------------------------------------
// Each accepted tick passes through the idle state and seven sequencer steps
// and yields one Q1.15 sample until sample_count samples have been
// produced. The tone state (phase, envelope, sample index, peak) sits in a
// four-entry memory with one port for reads and one for writes, so the
// sequencer reads the four entries one after another and writes them back one
// after another; that single access per cycle sets the rate. A result waiting
// in the output register does not block the next tick until its own write-back
// is done. After reset the state reads as a fresh tone without any clearing
// pass. Configuration writes are always taken and must be done while idle.
module decaying_sine_generator
    import dsg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    // sample channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_sample,
    output logic [14:0] o_peak,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int RW = SAMPLE_BITS - 1;
    localparam int PW = SAMPLE_BITS + 16;
    localparam logic [SINE_ADDR_BITS:0] QTR = (SINE_ADDR_BITS+1)'(1) << SINE_ADDR_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PH   = 8'b0000_0010,
        S_ENV  = 8'b0000_0100,
        S_IDX  = 8'b0000_1000,
        S_PK   = 8'b0001_0000,
        S_WENV = 8'b0010_0000,
        S_WIDX = 8'b0100_0000,
        S_WPK  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [30:0] r_phase_step;
    logic [15:0] r_amplitude;
    logic [31:0] r_decay;
    logic [31:0] r_count;

    logic        r_fresh;
    logic        r_clear;
    logic [31:0] r_phase;
    logic [31:0] r_env;
    logic [31:0] r_idx;
    logic [15:0] r_p;
    logic [16:0] r_m;
    logic        r_active;
    logic        r_last;
    logic [31:0] r_env_nxt;
    logic [15:0] r_smp;
    logic [14:0] r_peak_new;

    logic        r_o_valid;
    logic [15:0] r_o_sample;
    logic [14:0] r_o_peak;
    logic        r_o_last;

    t_mem_req    mem_req;
    logic [31:0] mem_rdata;
    logic [31:0] rd_sub;
    logic [SINE_ADDR_BITS:0] rom_addr;
    logic [SINE_ADDR_BITS:0] addr_raw;
    logic [RW-1:0]           rom_data;
    logic [PW-1:0]           prod_p;
    logic [47:0]             prod_m;
    logic [63:0]             prod_e;
    logic [16:0]             m_sat;
    logic [14:0]             mag_pk;
    logic                    in_acc;
    logic                    out_free;

    dsg_sine_rom #(
        .ADDR_BITS   (SINE_ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    dsg_state_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;

    // restart (or first tick after reset) replaces stored state by its start value
    always_comb begin
        rd_sub = mem_rdata;
        if (r_clear) begin
            rd_sub = (r_state == S_ENV) ? ENV_ONE : 32'd0;
        end
    end

    // quarter-wave addressing, mirrored in quadrants one and three
    always_comb begin
        addr_raw = {1'b0, rd_sub[29 -: SINE_ADDR_BITS]};
        rom_addr = rd_sub[30] ? (QTR - addr_raw) : addr_raw;
    end

    always_comb begin
        prod_p = PW'(rom_data) * PW'(r_amplitude) + (PW'(1) << (SAMPLE_BITS - 2));
        prod_m = 48'(r_p) * 48'(r_env) + (48'd1 << 30);
        prod_e = 64'(r_env) * 64'(r_decay);
    end

    // saturation, negative side keeps one extra step of magnitude
    always_comb begin
        if (r_phase[31]) begin
            m_sat = (r_m > 17'd32768) ? 17'd32768 : r_m;
        end else begin
            m_sat = (r_m > 17'd32767) ? 17'd32767 : r_m;
        end
        mag_pk = (m_sat > 17'd32767) ? 15'h7fff : m_sat[14:0];
    end

    always_comb begin
        n_state       = r_state;
        mem_req.we    = 1'b0;
        mem_req.waddr = ENT_PHASE;
        mem_req.wdata = 32'd0;
        mem_req.raddr = ENT_PHASE;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PH;
                end
            end
            S_PH: begin
                mem_req.raddr = ENT_ENV;
                n_state       = S_ENV;
            end
            S_ENV: begin
                mem_req.raddr = ENT_INDEX;
                n_state       = S_IDX;
            end
            S_IDX: begin
                mem_req.raddr = ENT_PEAK;
                n_state       = S_PK;
            end
            S_PK: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ENT_PHASE;
                mem_req.wdata = r_active ? (r_phase + {1'b0, r_phase_step}) : r_phase;
                n_state       = S_WENV;
            end
            S_WENV: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ENT_ENV;
                mem_req.wdata = r_active ? r_env_nxt : r_env;
                n_state       = S_WIDX;
            end
            S_WIDX: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ENT_INDEX;
                mem_req.wdata = r_active ? (r_idx + 32'd1) : r_idx;
                n_state       = S_WPK;
            end
            S_WPK: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ENT_PEAK;
                mem_req.wdata = {17'd0, r_peak_new};
                if (!r_active || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fresh      <= 1'b1;
            r_clear      <= 1'b0;
            r_o_valid    <= 1'b0;
            r_phase_step <= 31'd0;
            r_amplitude  <= 16'd32768;
            r_decay      <= 32'hffff_ffff;
            r_count      <= 32'd44100;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PHASE_STEP:   r_phase_step <= i_cfg_data[30:0];
                    REG_AMPLITUDE:    r_amplitude  <= i_cfg_data[15:0];
                    REG_DECAY_FACTOR: r_decay      <= i_cfg_data;
                    REG_SAMPLE_COUNT: r_count      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_clear <= i_restart || r_fresh;
            end
            if (r_state == S_WPK && n_state == S_IDLE) begin
                r_fresh <= 1'b0;
            end
            if (r_state == S_WPK && r_active && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_PH: begin
                r_phase <= rd_sub;
            end
            S_ENV: begin
                r_env <= rd_sub;
                r_p   <= prod_p[SAMPLE_BITS-1 +: 16];
            end
            S_IDX: begin
                r_idx    <= rd_sub;
                r_active <= rd_sub < r_count;
                r_last   <= (rd_sub + 32'd1) == r_count;
                r_m      <= prod_m[47:31];
            end
            S_PK: begin
                r_env_nxt <= prod_e[63:32];
                r_smp     <= r_phase[31] ? 16'(17'd0 - m_sat) : m_sat[15:0];
                if (r_active && mag_pk > rd_sub[14:0]) begin
                    r_peak_new <= mag_pk;
                end else begin
                    r_peak_new <= rd_sub[14:0];
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_WPK && r_active && out_free) begin
            r_o_sample <= r_smp;
            r_o_peak   <= r_peak_new;
            r_o_last   <= r_last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_sample = r_o_sample;
    assign o_peak   = r_o_peak;
    assign o_last   = r_o_last;

    a_emit_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_WPK))
        else $error("sample presented outside write-back");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PH))
        else $error("tick transfer did not start the sequencer");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_PK || r_state == S_WENV ||
                        r_state == S_WIDX || r_state == S_WPK))
        else $error("state memory written outside write-back");

    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sample[15]) |-> (o_peak >= o_sample[14:0]))
        else $error("peak below current sample");

endmodule
